FILE: sv/ecpid_pkg.sv
// Shared types and constants for the encoder PID duty controller.
// No dependencies; imported by every module of the block.
package ecpid_pkg;

    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 80;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        REG_TARGET_COUNT   = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_DUTY_MAX       = 3'd5
    } reg_index_t;

    localparam logic signed [31:0] RST_TARGET_COUNT   = 32'sd300;
    localparam logic [9:0]         RST_GAIN           = 10'd10;
    localparam logic [14:0]        RST_INTEGRAL_LIMIT = 15'd1000;
    localparam logic [15:0]        RST_DUTY_MAX       = 16'd20000;

    localparam logic signed [31:0] ERR_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] ERR_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] target_count;
        logic [9:0]         gain_p;
        logic [9:0]         gain_i;
        logic [9:0]         gain_d;
        logic [14:0]        integral_limit;
        logic [15:0]        duty_max;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] err;
        logic signed [15:0] integ;
        logic signed [32:0] deriv;
        logic signed [31:0] count;
    } tick_t;

endpackage

FILE: sv/ecpid_cfg.sv
// APB register file holding setpoint, gains and clamps.
// Depends on ecpid_pkg.
module ecpid_cfg
    import ecpid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;

    assign idx    = reg_index_t'(paddr[4:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_TARGET_COUNT:   cfg_next.target_count   = pwdata;
                REG_GAIN_P:         cfg_next.gain_p         = pwdata[9:0];
                REG_GAIN_I:         cfg_next.gain_i         = pwdata[9:0];
                REG_GAIN_D:         cfg_next.gain_d         = pwdata[9:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = pwdata[14:0];
                REG_DUTY_MAX:       cfg_next.duty_max       = pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET_COUNT:   prdata = cfg_reg.target_count;
            REG_GAIN_P:         prdata = {22'd0, cfg_reg.gain_p};
            REG_GAIN_I:         prdata = {22'd0, cfg_reg.gain_i};
            REG_GAIN_D:         prdata = {22'd0, cfg_reg.gain_d};
            REG_INTEGRAL_LIMIT: prdata = {17'd0, cfg_reg.integral_limit};
            REG_DUTY_MAX:       prdata = {16'd0, cfg_reg.duty_max};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_count   <= RST_TARGET_COUNT;
            cfg_reg.gain_p         <= RST_GAIN;
            cfg_reg.gain_i         <= RST_GAIN;
            cfg_reg.gain_d         <= RST_GAIN;
            cfg_reg.integral_limit <= RST_INTEGRAL_LIMIT;
            cfg_reg.duty_max       <= RST_DUTY_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/ecpid_state.sv
// Input register and state update: encoder count, saturated error,
// clamped integral and derivative. Depends on ecpid_pkg.
module ecpid_state
    import ecpid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                tick_valid,
    output tick_t               tick,
    input  logic                tick_ready
);

    logic               in_valid_reg;
    logic               in_kind_reg;
    logic               in_a_reg;
    logic               in_b_reg;
    logic signed [31:0] count_reg;
    logic signed [31:0] count_next;
    logic signed [15:0] integ_reg;
    logic signed [31:0] last_err_reg;
    logic               fire;

    logic signed [32:0] diff;
    logic signed [31:0] err;
    logic signed [33:0] isum;
    logic signed [33:0] lim;
    logic signed [33:0] integ_full;

    assign fire       = in_valid_reg && ((in_kind_reg == KIND_EDGE) || tick_ready);
    assign s_tready   = !in_valid_reg || fire;
    assign tick_valid = in_valid_reg && (in_kind_reg == KIND_TICK);

    always_comb
    begin
        count_next = (in_a_reg == in_b_reg) ? count_reg + 32'sd1 : count_reg - 32'sd1;

        diff = {cfg.target_count[31], cfg.target_count} - {count_reg[31], count_reg};
        if (diff[32] != diff[31])
            err = diff[32] ? ERR_MIN : ERR_MAX;
        else
            err = diff[31:0];

        isum = {{18{integ_reg[15]}}, integ_reg} + {{2{err[31]}}, err};
        lim  = {19'd0, cfg.integral_limit};
        priority if (isum > lim)
            integ_full = lim;
        else if (isum < -lim)
            integ_full = -lim;
        else
            integ_full = isum;

        tick.err   = err;
        tick.integ = integ_full[15:0];
        tick.deriv = {err[31], err} - {last_err_reg[31], last_err_reg};
        tick.count = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            count_reg    <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
            begin
                if (in_kind_reg == KIND_EDGE)
                begin
                    count_reg <= count_next;
                end
                else
                begin
                    integ_reg    <= integ_full[15:0];
                    last_err_reg <= err;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_a_reg    <= s_tdata[0];
            in_b_reg    <= s_tdata[1];
        end
    end

endmodule

FILE: sv/ecpid_mac.sv
// PID products, sum and duty clamp with the output register.
// Depends on ecpid_pkg.
module ecpid_mac
    import ecpid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                tick_valid,
    input  tick_t               tick,
    output logic                tick_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic               prod_valid_reg;
    logic signed [42:0] prod_p_reg;
    logic signed [26:0] prod_i_reg;
    logic signed [43:0] prod_d_reg;
    logic signed [31:0] prod_err_reg;
    logic signed [31:0] prod_count_reg;
    logic               prod_ready;

    logic               out_valid_reg;
    logic [15:0]        duty_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] count_reg;
    logic               out_ready;

    logic signed [45:0] sum;
    logic [15:0]        duty_next;

    assign out_ready  = !out_valid_reg || m_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign tick_ready = prod_ready;

    always_comb
    begin
        sum = {{3{prod_p_reg[42]}}, prod_p_reg}
            + {{19{prod_i_reg[26]}}, prod_i_reg}
            + {{2{prod_d_reg[43]}}, prod_d_reg};
        priority if (sum[45])
            duty_next = '0;
        else if (sum > $signed({30'd0, cfg.duty_max}))
            duty_next = cfg.duty_max;
        else
            duty_next = sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= tick_valid;
            if (out_ready)
                out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && tick_valid)
        begin
            prod_p_reg     <= $signed({1'b0, cfg.gain_p}) * tick.err;
            prod_i_reg     <= $signed({1'b0, cfg.gain_i}) * tick.integ;
            prod_d_reg     <= $signed({1'b0, cfg.gain_d}) * tick.deriv;
            prod_err_reg   <= tick.err;
            prod_count_reg <= tick.count;
        end
        if (out_ready && prod_valid_reg)
        begin
            duty_reg  <= duty_next;
            err_reg   <= prod_err_reg;
            count_reg <= prod_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {count_reg, err_reg, duty_reg};

endmodule

FILE: sv/encoder_pid_duty_control.sv
// Top level of the encoder PID duty controller.
// Depends on ecpid_pkg, ecpid_cfg, ecpid_state and ecpid_mac.
//
// Input stream: s_tuser is the item kind (0 encoder edge, 1 control tick);
// s_tdata bit 0 is channel A, bit 1 channel B. An edge moves the position
// count up when A equals B, down otherwise. A tick runs the PID update and
// yields one result on the output stream: duty, saturated error, count.
// Edges give no result.
// A tick's result reaches m_tvalid through the input register (loaded at the
// accepting edge), then the multiply register, then the output register.
// Throughput: one item per cycle unless stalled, edges and ticks in any mix.
// Each stage holds its item while the next is full, so a stalled receiver
// fills the pipeline and only then drops s_tready; edges keep flowing as
// long as the input register is not holding a tick.
// Reset clears count, integral and previous error, empties the pipeline and
// loads the default registers (setpoint 300, gains 10, integral limit 1000,
// duty max 20000). Users write registers over APB while idle; not enforced.
module encoder_pid_duty_control
    import ecpid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] chan_a, [1] chan_b, rest zero
    input  logic                s_tuser,   // [0] kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] duty, [47:16] error_value,
                                           // [79:48] count_value
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [CFG_W-1:0]    pwdata,
    output logic [CFG_W-1:0]    prdata,
    output logic                pready
);

    cfg_t  cfg;
    tick_t tick;
    logic  tick_valid;
    logic  tick_ready;

    ecpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ecpid_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .tick_valid (tick_valid),
        .tick       (tick),
        .tick_ready (tick_ready)
    );

    ecpid_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick       (tick),
        .tick_ready (tick_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
